// File: src/tlca_pkg.sv
// Shared constants, types and helpers of the lowest common ancestor block.
`default_nettype none

package tlca_pkg;

	localparam int NODES     = 1024;
	localparam int LEVELS    = 10;
	localparam int FIELD_W   = 10;
	localparam int NODE_W    = $clog2(NODES);
	localparam int DEPTH_W   = 10;
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEPTH_MAX = (2 ** DEPTH_W) - 1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef logic [NODE_W-1:0]              node_t;
	typedef logic [DEPTH_W-1:0]             depth_t;
	typedef logic [LVL_W-1:0]               lvl_t;
	typedef logic [LEVELS-1:0][NODE_W-1:0]  row_t;

	// One memory word: a node's depth and its whole row of 2^i ancestors.
	typedef struct packed {
		depth_t depth;
		row_t   row;
	} entry_t;

	// Requests from the sequencer to the node memory.
	typedef struct packed {
		logic   we;
		node_t  waddr;
		entry_t wdata;
		node_t  raddr_u;
		node_t  raddr_v;
	} mem_req_t;

	// Node numbers outside the tree fold onto the sentinel node.
	function automatic node_t clip_node(input logic [FIELD_W-1:0] raw);
		node_t res;
		res = (32'(raw) < NODES) ? NODE_W'(raw) : '0;
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/tlca_mem.sv
// Node memory: one write port and two registered read ports.
`default_nettype none

module tlca_mem (
	input  wire logic              clk,
	input  wire tlca_pkg::mem_req_t req,
	output tlca_pkg::entry_t       rd_u,
	output tlca_pkg::entry_t       rd_v
);

	tlca_pkg::entry_t mem_q [tlca_pkg::NODES];
	tlca_pkg::entry_t rd_u_q;
	tlca_pkg::entry_t rd_v_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_u_q <= mem_q[req.raddr_u];
		rd_v_q <= mem_q[req.raddr_v];
	end

	assign rd_u = rd_u_q;
	assign rd_v = rd_v_q;

endmodule

`default_nettype wire

// File: src/tlca_ctrl.sv
// Sequencer that clears the memory, loads node rows and walks the lifting table.
`default_nettype none

module tlca_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  operation,
	input  wire logic [tlca_pkg::FIELD_W-1:0] node_a,
	input  wire logic [tlca_pkg::FIELD_W-1:0] node_b,
	output tlca_pkg::mem_req_t         mem_req,
	input  wire tlca_pkg::entry_t      rd_u,
	input  wire tlca_pkg::entry_t      rd_v,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output tlca_pkg::node_t            res_node
);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_IDEP   = 4'd2;
	localparam logic [3:0] ST_IFILL  = 4'd3;
	localparam logic [3:0] ST_IWRITE = 4'd4;
	localparam logic [3:0] ST_QSWAP  = 4'd5;
	localparam logic [3:0] ST_LIFT   = 4'd6;
	localparam logic [3:0] ST_CHECK  = 4'd7;
	localparam logic [3:0] ST_JUMP   = 4'd8;
	localparam logic [3:0] ST_FINAL  = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	localparam tlca_pkg::lvl_t  LVL_TOP  = tlca_pkg::LVL_W'(tlca_pkg::LEVELS - 1);
	localparam tlca_pkg::node_t NODE_TOP = tlca_pkg::NODE_W'(tlca_pkg::NODES - 1);

	logic [3:0]       state_q;
	tlca_pkg::lvl_t   lvl_q;
	tlca_pkg::node_t  clr_q;
	tlca_pkg::node_t  u_q;
	tlca_pkg::node_t  v_q;
	tlca_pkg::node_t  node_q;
	tlca_pkg::node_t  res_q;
	tlca_pkg::depth_t dv_q;
	tlca_pkg::depth_t depth_q;
	tlca_pkg::row_t   row_q;

	logic             accept;
	logic             swap;
	tlca_pkg::node_t  a_clip;
	tlca_pkg::node_t  b_clip;
	tlca_pkg::node_t  u_nxt;
	tlca_pkg::node_t  v_nxt;
	tlca_pkg::node_t  fill_entry;
	tlca_pkg::depth_t diff;
	tlca_pkg::lvl_t   lvl_prev;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign a_clip    = tlca_pkg::clip_node(node_a);
	assign b_clip    = tlca_pkg::clip_node(node_b);
	assign swap      = rd_u.depth < rd_v.depth;
	assign diff      = rd_u.depth - dv_q;
	assign lvl_prev  = lvl_q - tlca_pkg::LVL_W'(1);
	assign res_valid = (state_q == ST_DONE);
	assign res_node  = res_q;

	// When the row being built names its own node, the entry just written is used.
	assign fill_entry = (u_q == node_q) ? u_q : rd_u.row[lvl_prev];

	// The read addresses are the next values of the node registers, so the read data lines up with them.
	always_comb begin
		u_nxt = u_q;
		v_nxt = v_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == tlca_pkg::OP_QUERY) begin
						u_nxt = a_clip;
						v_nxt = b_clip;
					end else begin
						u_nxt = b_clip;
					end
				end
			end
			ST_QSWAP: begin
				if (swap) begin
					u_nxt = v_q;
					v_nxt = u_q;
				end
			end
			ST_LIFT: begin
				if (diff[lvl_q]) begin
					u_nxt = rd_u.row[lvl_q];
				end
			end
			ST_JUMP: begin
				if (rd_u.row[lvl_q] != rd_v.row[lvl_q]) begin
					u_nxt = rd_u.row[lvl_q];
					v_nxt = rd_v.row[lvl_q];
				end
			end
			ST_IFILL: begin
				u_nxt = fill_entry;
			end
			default: begin
				u_nxt = u_q;
				v_nxt = v_q;
			end
		endcase
	end

	always_comb begin
		mem_req.we          = 1'b0;
		mem_req.waddr       = node_q;
		mem_req.wdata.depth = depth_q;
		mem_req.wdata.row   = row_q;
		mem_req.raddr_u     = u_nxt;
		mem_req.raddr_v     = v_nxt;
		if (state_q == ST_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_q;
			mem_req.wdata = '0;
		end else if (state_q == ST_IWRITE) begin
			mem_req.we = (node_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			lvl_q   <= '0;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + tlca_pkg::NODE_W'(1);
					if (clr_q == NODE_TOP) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (operation == tlca_pkg::OP_QUERY) ? ST_QSWAP : ST_IDEP;
					end
				end
				ST_IDEP: begin
					if (tlca_pkg::LEVELS > 1) begin
						lvl_q   <= tlca_pkg::LVL_W'(1);
						state_q <= ST_IFILL;
					end else begin
						state_q <= ST_IWRITE;
					end
				end
				ST_IFILL: begin
					if (lvl_q == LVL_TOP) begin
						state_q <= ST_IWRITE;
					end else begin
						lvl_q <= lvl_q + tlca_pkg::LVL_W'(1);
					end
				end
				ST_IWRITE: begin
					state_q <= ST_IDLE;
				end
				ST_QSWAP: begin
					lvl_q   <= LVL_TOP;
					state_q <= ST_LIFT;
				end
				ST_LIFT: begin
					if (lvl_q == '0) begin
						state_q <= ST_CHECK;
					end else begin
						lvl_q <= lvl_prev;
					end
				end
				ST_CHECK: begin
					lvl_q   <= LVL_TOP;
					state_q <= (u_q == v_q) ? ST_DONE : ST_JUMP;
				end
				ST_JUMP: begin
					if (lvl_q == '0) begin
						state_q <= ST_FINAL;
					end else begin
						lvl_q <= lvl_prev;
					end
				end
				ST_FINAL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		u_q <= u_nxt;
		v_q <= v_nxt;
		if (accept) begin
			node_q   <= a_clip;
			row_q[0] <= b_clip;
		end
		if (state_q == ST_IDEP) begin
			if (u_q == '0) begin
				depth_q <= '0;
			end else if (rd_u.depth == tlca_pkg::DEPTH_W'(tlca_pkg::DEPTH_MAX)) begin
				depth_q <= rd_u.depth;
			end else begin
				depth_q <= rd_u.depth + tlca_pkg::DEPTH_W'(1);
			end
		end
		if (state_q == ST_IFILL) begin
			row_q[lvl_q] <= fill_entry;
		end
		if (state_q == ST_QSWAP) begin
			dv_q <= swap ? rd_u.depth : rd_v.depth;
		end
		if (state_q == ST_CHECK) begin
			res_q <= u_q;
		end
		if (state_q == ST_FINAL) begin
			res_q <= rd_u.row[0];
		end
	end

endmodule

`default_nettype wire

// File: src/tree_lca_binary_lifting.sv
// Top level of the lowest common ancestor block with binary lifting.
//
//   channel  direction  handshake            fields
//   input    request    in_valid / in_ready  operation, node_a, node_b
//   output   answer     out_valid/out_ready  common_ancestor
//
// After reset the block clears its node memory, one node per cycle, for
// all 1024 nodes with in_ready low. An insert request does one memory read
// per ancestor level of the new row. A query request ends after the
// lifting pass when the lifted node already equals the other, else after
// the jump pass and a parent read; each lifting level is one read of the
// shared node memory and one compare. A result waits in the output register
// while the next request is taken; the sequencer stalls only when that
// register is still full at the end of the next query.
`default_nettype none

module tree_lca_binary_lifting (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         operation,
	input  wire logic [tlca_pkg::FIELD_W-1:0] node_a,
	input  wire logic [tlca_pkg::FIELD_W-1:0] node_b,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [tlca_pkg::FIELD_W-1:0]      common_ancestor
);

	tlca_pkg::mem_req_t mem_req;
	tlca_pkg::entry_t   rd_u;
	tlca_pkg::entry_t   rd_v;
	tlca_pkg::node_t    res_node;
	logic               res_valid;
	logic               res_ready;
	logic               out_valid_q;
	logic [tlca_pkg::FIELD_W-1:0] common_ancestor_q;

	// The sequencer owns the memory ports and all lifting state.
	tlca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.node_a    (node_a),
		.node_b    (node_b),
		.mem_req   (mem_req),
		.rd_u      (rd_u),
		.rd_v      (rd_v),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_node  (res_node)
	);

	// Depth and ancestor row of every node share one word.
	tlca_mem u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rd_u (rd_u),
		.rd_v (rd_v)
	);

	// The output register takes a new answer when it is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			common_ancestor_q <= tlca_pkg::FIELD_W'(res_node);
		end
	end

	assign out_valid       = out_valid_q;
	assign common_ancestor = common_ancestor_q;

endmodule

`default_nettype wire

// File: src/tlca_checker.sv
// Port checker for the lowest common ancestor block and its bind.
`default_nettype none

module tlca_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         operation,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [tlca_pkg::FIELD_W-1:0] common_ancestor
);

	// An accepted request leaves the block busy in the cycle after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while block still ready");

	// The memory clearing pass follows every reset.
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("request taken during memory clearing");

	// A query that is accepted cannot finish in the next cycle.
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == tlca_pkg::OP_QUERY) && !out_valid
		|=> !out_valid)
		else $error("answer appeared too early");

	// A stalled answer holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(common_ancestor))
		else $error("stalled answer changed");

endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.operation       (operation),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.common_ancestor (common_ancestor)
);

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the binary-lifting lowest common ancestor block.
`timescale 1ns / 100ps

module tb;

	localparam int RUN_LIMIT  = 600000;
	localparam int TAIL_WAIT  = 40;
	localparam int MAX_WAIT   = 14;
	localparam int MIXED_SIZE = 650;

	typedef struct packed {
		logic                         op;
		logic [tlca_pkg::FIELD_W-1:0] a;
		logic [tlca_pkg::FIELD_W-1:0] b;
	} lca_req_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         operation = tlca_pkg::OP_INSERT;
	logic [tlca_pkg::FIELD_W-1:0] node_a = '0;
	logic [tlca_pkg::FIELD_W-1:0] node_b = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [tlca_pkg::FIELD_W-1:0] common_ancestor;

	// Our own copy of the tree: the 2^i ancestor row and the depth of every node.
	tlca_pkg::node_t  lift_row [tlca_pkg::NODES][tlca_pkg::LEVELS];
	tlca_pkg::depth_t lift_depth [tlca_pkg::NODES];

	lca_req_t        pending[$];
	tlca_pkg::node_t lca_expected[$];
	lca_req_t        now_req;

	int  planned = 0;
	int  requests_done = 0;
	int  inserts_done = 0;
	int  queries_done = 0;
	int  answers_checked = 0;
	int  fails = 0;
	int  cycles = 0;
	int  in_hold = 0;
	int  out_hold = 0;
	bit  in_calm = 1'b0;
	bit  out_calm = 1'b0;

	int  chain [1023];
	int  members [40];
	int  k, nq, parent, swap_idx, tmp, qa, qb;

	tree_lca_binary_lifting u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.node_a         (node_a),
		.node_b         (node_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.common_ancestor(common_ancestor)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Insert: the row is built in level order and each level reads what the
	// table holds at that moment, so a self parent or a re-insert sees its own
	// freshly written entries. Node 0 is the sentinel and never changes.
	// Every 10-bit node number is below NODES, so no folding onto node 0 occurs.
	function automatic void load_node(tlca_pkg::node_t n, tlca_pkg::node_t p);
		if (n == '0)
			return;
		if (p == '0) begin
			lift_depth[n] = '0;
		end else begin
			lift_depth[n] =
				(lift_depth[p] == tlca_pkg::depth_t'(tlca_pkg::DEPTH_MAX)) ?
				tlca_pkg::depth_t'(tlca_pkg::DEPTH_MAX) : lift_depth[p] + 1'b1;
		end
		lift_row[n][0] = p;
		for (int i = 1; i < tlca_pkg::LEVELS; i++)
			lift_row[n][i] = lift_row[lift_row[n][i-1]][i-1];
	endfunction

	// Query: lift the deeper node by the bits of the depth difference, then
	// lift both while their ancestors differ. The difference is recomputed at
	// every level from the stored depths, so inconsistent trees wrap around.
	function automatic tlca_pkg::node_t common_of(tlca_pkg::node_t a,
		tlca_pkg::node_t b);
		tlca_pkg::node_t u, v, t, pu, pv;
		logic [31:0]     rise;
		u = a;
		v = b;
		if (lift_depth[u] < lift_depth[v]) begin
			t = u;
			u = v;
			v = t;
		end
		for (int i = tlca_pkg::LEVELS - 1; i >= 0; i--) begin
			rise = 32'(lift_depth[u]) - 32'(lift_depth[v]);
			if (rise[i])
				u = lift_row[u][i];
		end
		if (u == v)
			return u;
		for (int i = tlca_pkg::LEVELS - 1; i >= 0; i--) begin
			pu = lift_row[u][i];
			pv = lift_row[v][i];
			if (pu != pv) begin
				u = pu;
				v = pv;
			end
		end
		return lift_row[u][0];
	endfunction

	task automatic enqueue_request(input logic op, input int a, input int b);
		lca_req_t r;
		r.op = op;
		r.a  = tlca_pkg::FIELD_W'(a);
		r.b  = tlca_pkg::FIELD_W'(b);
		pending = {pending, r};
		planned++;
	endtask

	task automatic enqueue_noise();
		if ($urandom_range(0, 9) == 0)
			enqueue_request(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
				$urandom_range(0, 1023));
	endtask

	// Request driver: presents the next pending request after a random hold,
	// and updates the tree copy or records the expected answer on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= tlca_pkg::OP_INSERT;
			node_a    <= '0;
			node_b    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				if (now_req.op == tlca_pkg::OP_INSERT) begin
					load_node(tlca_pkg::node_t'(now_req.a), tlca_pkg::node_t'(now_req.b));
					inserts_done++;
				end else begin
					lca_expected = {lca_expected,
						common_of(tlca_pkg::node_t'(now_req.a),
						tlca_pkg::node_t'(now_req.b))};
					queries_done++;
				end
				requests_done++;
				if ($urandom_range(0, 31) == 0)
					in_calm = !in_calm;
				in_hold = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (!in_valid || in_ready) begin
				if (in_hold == 0 && pending.size() != 0) begin
					now_req = pending.pop_front();
					in_valid  <= 1'b1;
					operation <= now_req.op;
					node_a    <= now_req.a;
					node_b    <= now_req.b;
				end else begin
					in_valid <= 1'b0;
					if (in_hold != 0)
						in_hold--;
				end
			end
		end
	end

	// Answer monitor: checks each accepted answer against the oldest
	// expectation, then holds ready low for a random number of valid cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (lca_expected.size() == 0) begin
					$error("common_ancestor: answer %0d with no query waiting",
						common_ancestor);
					fails++;
				end else begin
					if (common_ancestor !== lca_expected[0]) begin
						$error("common_ancestor: expected %0d, actual %0d",
							lca_expected[0], common_ancestor);
						fails++;
					end
					void'(lca_expected.pop_front());
					answers_checked++;
				end
				if ($urandom_range(0, 31) == 0)
					out_calm = !out_calm;
				out_hold = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end else if (out_valid && out_hold != 0) begin
				out_hold--;
			end
			out_ready <= (out_hold == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$error("timeout after %0d cycles, %0d answers still expected",
				cycles, lca_expected.size());
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		for (int n = 0; n < tlca_pkg::NODES; n++) begin
			lift_depth[n] = '0;
			for (int i = 0; i < tlca_pkg::LEVELS; i++)
				lift_row[n][i] = '0;
		end

		// Directed part: empty tree, sentinel insert, a small tree with both
		// extreme node numbers, a parent that was never inserted, a self
		// parent and a re-insert that moves a node under another branch.
		enqueue_request(tlca_pkg::OP_QUERY, 0, 0);
		enqueue_request(tlca_pkg::OP_INSERT, 0, 5);
		enqueue_request(tlca_pkg::OP_QUERY, 0, 1023);
		enqueue_request(tlca_pkg::OP_INSERT, 1, 0);
		enqueue_request(tlca_pkg::OP_INSERT, 2, 1);
		enqueue_request(tlca_pkg::OP_INSERT, 3, 1);
		enqueue_request(tlca_pkg::OP_INSERT, 4, 2);
		enqueue_request(tlca_pkg::OP_INSERT, 1023, 4);
		enqueue_request(tlca_pkg::OP_INSERT, 5, 3);
		enqueue_request(tlca_pkg::OP_QUERY, 1023, 5);
		enqueue_request(tlca_pkg::OP_QUERY, 4, 1023);
		enqueue_request(tlca_pkg::OP_QUERY, 2, 2);
		enqueue_request(tlca_pkg::OP_QUERY, 1023, 0);
		enqueue_request(tlca_pkg::OP_INSERT, 600, 700);
		enqueue_request(tlca_pkg::OP_QUERY, 600, 1023);
		enqueue_request(tlca_pkg::OP_INSERT, 7, 7);
		enqueue_request(tlca_pkg::OP_QUERY, 7, 1);
		enqueue_request(tlca_pkg::OP_INSERT, 2, 5);
		enqueue_request(tlca_pkg::OP_QUERY, 4, 5);
		enqueue_request(tlca_pkg::OP_QUERY, 1023, 600);
		enqueue_request(tlca_pkg::OP_INSERT, 1023, 1023);
		enqueue_request(tlca_pkg::OP_QUERY, 1023, 3);
		enqueue_request(tlca_pkg::OP_INSERT, 512, 0);
		enqueue_request(tlca_pkg::OP_QUERY, 512, 1);

		// Random trees loaded parent first, each followed by queries among its
		// nodes, with some noise requests mixed in.
		while (planned < MIXED_SIZE) begin
			k = $urandom_range(4, 40);
			for (int j = 0; j < k; j++) begin
				members[j] = $urandom_range(1, 1023);
				if (j == 0)
					parent = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : 0;
				else if ($urandom_range(0, 1) == 0)
					parent = members[j-1];
				else
					parent = members[$urandom_range(0, j - 1)];
				enqueue_request(tlca_pkg::OP_INSERT, members[j], parent);
				enqueue_noise();
			end
			nq = $urandom_range(k / 2, k);
			for (int j = 0; j < nq; j++) begin
				qa = members[$urandom_range(0, k - 1)];
				qb = members[$urandom_range(0, k - 1)];
				if ($urandom_range(0, 15) == 0)
					qb = $urandom_range(0, 1) ? 0 : $urandom_range(0, 1023);
				enqueue_request(tlca_pkg::OP_QUERY, qa, qb);
				enqueue_noise();
			end
		end

		// One chain through every node in random order, so that depth
		// differences reach the top lifting level, with queries along the way.
		for (int i = 0; i < 1023; i++)
			chain[i] = i + 1;
		for (int i = 1022; i > 0; i--) begin
			swap_idx = $urandom_range(0, i);
			tmp = chain[i];
			chain[i] = chain[swap_idx];
			chain[swap_idx] = tmp;
		end
		for (int i = 0; i < 1023; i++) begin
			enqueue_request(tlca_pkg::OP_INSERT, chain[i], (i == 0) ? 0 : chain[i-1]);
			if ($urandom_range(0, 3) == 0)
				enqueue_request(tlca_pkg::OP_QUERY, chain[$urandom_range(0, i)],
					chain[$urandom_range(0, i)]);
		end

		// Closing the chain into a loop drives the depth into saturation at its maximum.
		enqueue_request(tlca_pkg::OP_INSERT, chain[0], chain[1022]);
		enqueue_request(tlca_pkg::OP_INSERT, chain[1], chain[0]);
		enqueue_request(tlca_pkg::OP_INSERT, chain[2], chain[1]);
		enqueue_request(tlca_pkg::OP_QUERY, chain[1], chain[500]);
		enqueue_request(tlca_pkg::OP_QUERY, chain[0], chain[1022]);
		enqueue_request(tlca_pkg::OP_QUERY, chain[2], chain[3]);
		enqueue_request(tlca_pkg::OP_QUERY, chain[1022], chain[1]);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_done != planned || lca_expected.size() != 0)
			@(negedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("tb: %0d requests (%0d inserts, %0d queries), %0d answers checked",
			requests_done, inserts_done, queries_done, answers_checked);
		$display("tb: random trees, a full-depth chain and depth saturation, %0d errors",
			fails);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
